// ----- rtl/huffman_length_and_code_build_macros.svh -----
// Assertion shorthands shared by the RTL; clk and rst_n are taken from the enclosing module.
`ifndef HUFFMAN_LENGTH_AND_CODE_BUILD_MACROS_SVH
`define HUFFMAN_LENGTH_AND_CODE_BUILD_MACROS_SVH

// Same-cycle implication, ignored while in reset.
`define HLCB_ASSERT_IMP(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, ignored while in reset.
`define HLCB_ASSERT_NXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- rtl/hlcb_pkg.sv -----
package hlcb_pkg;

    localparam int MAX_SYMBOLS = 64;
    localparam int ADDR_W      = $clog2(MAX_SYMBOLS);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int PTR_W       = CNT_W + 1;

    localparam int FREQ_W      = 16;
    localparam int WEIGHT_W    = 22;
    localparam int POS_W       = 6;
    localparam int LEN_W       = 6;
    localparam int CODE_W      = 32;
    localparam int DEPTH_LIMIT = 2 ** LEN_W;

    localparam logic [LEN_W-1:0]        LEN_FILL  = '1;
    localparam logic signed [PTR_W-1:0] PTR_ONE   = PTR_W'(1);
    localparam logic signed [PTR_W-1:0] PTR_TWO   = PTR_W'(2);
    localparam logic signed [PTR_W-1:0] PTR_THREE = PTR_W'(3);

    typedef enum logic [5:0] {
        OP_IDLE,
        OP_LOAD,
        OP_FEW,
        OP_P_INIT,
        OP_P_RD0,
        OP_P_RD1,
        OP_P_WR0,
        OP_P_CHK,
        OP_P1A,
        OP_P1B,
        OP_P1C,
        OP_P1D,
        OP_P2A,
        OP_P2B,
        OP_P2C,
        OP_P2D,
        OP_P2E,
        OP_D_INIT,
        OP_D_CHK,
        OP_D_R0,
        OP_D_R1,
        OP_D_W,
        OP_L_INIT,
        OP_L_CHK,
        OP_L_UI,
        OP_L_UR,
        OP_L_UC,
        OP_L_A,
        OP_L_FILL,
        OP_C_INIT,
        OP_C_0,
        OP_C_CHK,
        OP_C_R,
        OP_C_W,
        OP_E_INIT,
        OP_E_R,
        OP_E_O
    } op_t;

    typedef struct packed {
        op_t  op;
        logic fire;
    } cmd_t;

    typedef struct packed {
        logic close;
        logic count_zero;
        logic out_free;
        logic i_pos;
        logic i_lt_n;
        logic i_nonneg;
        logic match;
        logic avail_more;
        logic depth_go;
        logic next_lt_n;
        logic emit_last;
    } sts_t;

endpackage

// ----- rtl/hlcb_ctrl.sv -----
`include "huffman_length_and_code_build_macros.svh"

module hlcb_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  hlcb_pkg::sts_t sts,
    output hlcb_pkg::cmd_t cmd
);
    import hlcb_pkg::*;

    localparam int STATE_W = 36;

    typedef enum logic [STATE_W-1:0] {
        ST_LOAD   = STATE_W'(1) << 0,
        ST_FEW    = STATE_W'(1) << 1,
        ST_P_INIT = STATE_W'(1) << 2,
        ST_P_RD0  = STATE_W'(1) << 3,
        ST_P_RD1  = STATE_W'(1) << 4,
        ST_P_WR0  = STATE_W'(1) << 5,
        ST_P_CHK  = STATE_W'(1) << 6,
        ST_P1A    = STATE_W'(1) << 7,
        ST_P1B    = STATE_W'(1) << 8,
        ST_P1C    = STATE_W'(1) << 9,
        ST_P1D    = STATE_W'(1) << 10,
        ST_P2A    = STATE_W'(1) << 11,
        ST_P2B    = STATE_W'(1) << 12,
        ST_P2C    = STATE_W'(1) << 13,
        ST_P2D    = STATE_W'(1) << 14,
        ST_P2E    = STATE_W'(1) << 15,
        ST_D_INIT = STATE_W'(1) << 16,
        ST_D_CHK  = STATE_W'(1) << 17,
        ST_D_R0   = STATE_W'(1) << 18,
        ST_D_R1   = STATE_W'(1) << 19,
        ST_D_W    = STATE_W'(1) << 20,
        ST_L_INIT = STATE_W'(1) << 21,
        ST_L_CHK  = STATE_W'(1) << 22,
        ST_L_UI   = STATE_W'(1) << 23,
        ST_L_UR   = STATE_W'(1) << 24,
        ST_L_UC   = STATE_W'(1) << 25,
        ST_L_A    = STATE_W'(1) << 26,
        ST_L_FILL = STATE_W'(1) << 27,
        ST_C_INIT = STATE_W'(1) << 28,
        ST_C_0    = STATE_W'(1) << 29,
        ST_C_CHK  = STATE_W'(1) << 30,
        ST_C_R    = STATE_W'(1) << 31,
        ST_C_W    = STATE_W'(1) << 32,
        ST_E_INIT = STATE_W'(1) << 33,
        ST_E_R    = STATE_W'(1) << 34,
        ST_E_O    = STATE_W'(1) << 35
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.op     = OP_IDLE;
        cmd.fire   = 1'b1;
        in_ready   = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                cmd.op   = OP_LOAD;
                cmd.fire = in_valid;
                if (in_valid && sts.close)
                begin
                    state_next = sts.count_zero ? ST_FEW : ST_P_INIT;
                end
            end
            ST_FEW:
            begin
                cmd.op   = OP_FEW;
                cmd.fire = sts.out_free;
                if (sts.out_free)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_P_INIT: begin cmd.op = OP_P_INIT; state_next = ST_P_RD0; end
            ST_P_RD0:  begin cmd.op = OP_P_RD0;  state_next = ST_P_RD1; end
            ST_P_RD1:  begin cmd.op = OP_P_RD1;  state_next = ST_P_WR0; end
            ST_P_WR0:  begin cmd.op = OP_P_WR0;  state_next = ST_P_CHK; end
            ST_P_CHK:
            begin
                cmd.op     = OP_P_CHK;
                state_next = sts.i_pos ? ST_P1A : ST_D_INIT;
            end
            ST_P1A:    begin cmd.op = OP_P1A;    state_next = ST_P1B;   end
            ST_P1B:    begin cmd.op = OP_P1B;    state_next = ST_P1C;   end
            ST_P1C:    begin cmd.op = OP_P1C;    state_next = ST_P1D;   end
            ST_P1D:    begin cmd.op = OP_P1D;    state_next = ST_P2A;   end
            ST_P2A:    begin cmd.op = OP_P2A;    state_next = ST_P2B;   end
            ST_P2B:    begin cmd.op = OP_P2B;    state_next = ST_P2C;   end
            ST_P2C:    begin cmd.op = OP_P2C;    state_next = ST_P2D;   end
            ST_P2D:    begin cmd.op = OP_P2D;    state_next = ST_P2E;   end
            ST_P2E:    begin cmd.op = OP_P2E;    state_next = ST_P_CHK; end
            ST_D_INIT: begin cmd.op = OP_D_INIT; state_next = ST_D_CHK; end
            ST_D_CHK:
            begin
                cmd.op     = OP_D_CHK;
                state_next = sts.i_lt_n ? ST_D_R0 : ST_L_INIT;
            end
            ST_D_R0:   begin cmd.op = OP_D_R0;   state_next = ST_D_R1;  end
            ST_D_R1:   begin cmd.op = OP_D_R1;   state_next = ST_D_W;   end
            ST_D_W:    begin cmd.op = OP_D_W;    state_next = ST_D_CHK; end
            ST_L_INIT: begin cmd.op = OP_L_INIT; state_next = ST_L_CHK; end
            ST_L_CHK:
            begin
                cmd.op     = OP_L_CHK;
                state_next = sts.depth_go ? ST_L_UI : ST_L_FILL;
            end
            ST_L_UI:   begin cmd.op = OP_L_UI;   state_next = ST_L_UR;  end
            ST_L_UR:   begin cmd.op = OP_L_UR;   state_next = ST_L_UC;  end
            ST_L_UC:
            begin
                cmd.op     = OP_L_UC;
                state_next = sts.match ? ST_L_UR : ST_L_A;
            end
            ST_L_A:
            begin
                cmd.op     = OP_L_A;
                state_next = sts.avail_more ? ST_L_A : ST_L_CHK;
            end
            ST_L_FILL:
            begin
                cmd.op     = OP_L_FILL;
                state_next = sts.next_lt_n ? ST_L_FILL : ST_C_INIT;
            end
            ST_C_INIT: begin cmd.op = OP_C_INIT; state_next = ST_C_0;   end
            ST_C_0:    begin cmd.op = OP_C_0;    state_next = ST_C_CHK; end
            ST_C_CHK:
            begin
                cmd.op     = OP_C_CHK;
                state_next = sts.i_nonneg ? ST_C_R : ST_E_INIT;
            end
            ST_C_R:    begin cmd.op = OP_C_R;    state_next = ST_C_W;   end
            ST_C_W:    begin cmd.op = OP_C_W;    state_next = ST_C_CHK; end
            ST_E_INIT: begin cmd.op = OP_E_INIT; state_next = ST_E_R;   end
            ST_E_R:    begin cmd.op = OP_E_R;    state_next = ST_E_O;   end
            ST_E_O:
            begin
                cmd.op   = OP_E_O;
                cmd.fire = sts.out_free;
                if (sts.out_free)
                begin
                    state_next = sts.emit_last ? ST_LOAD : ST_E_R;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    `HLCB_ASSERT_NXT(a_last_result_reopens, (state_reg == ST_E_O) && sts.out_free && sts.emit_last, in_ready, "set did not reopen after its last result")
    `HLCB_ASSERT_NXT(a_single_symbol_path, (state_reg == ST_LOAD) && in_valid && sts.close && sts.count_zero, (state_reg == ST_FEW), "single symbol set missed the error result")

endmodule

// ----- rtl/hlcb_datapath.sv -----
`include "huffman_length_and_code_build_macros.svh"

module hlcb_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  hlcb_pkg::cmd_t                cmd,
    output hlcb_pkg::sts_t                sts,
    input  logic [hlcb_pkg::FREQ_W-1:0]   frequency,
    input  logic                          last_item,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [hlcb_pkg::POS_W-1:0]    position,
    output logic [hlcb_pkg::LEN_W-1:0]    code_length,
    output logic [hlcb_pkg::CODE_W-1:0]   code_word,
    output logic                          too_few,
    output logic                          last_result
);
    import hlcb_pkg::*;

    logic [WEIGHT_W-1:0] w_mem [MAX_SYMBOLS];
    logic [LEN_W-1:0]    l_mem [MAX_SYMBOLS];
    logic [CODE_W-1:0]   c_mem [MAX_SYMBOLS];

    logic                w_we;
    logic [ADDR_W-1:0]   w_wa;
    logic [ADDR_W-1:0]   w_ra;
    logic [WEIGHT_W-1:0] w_wd;
    logic [WEIGHT_W-1:0] w_rd_reg;
    logic                l_we;
    logic [ADDR_W-1:0]   l_wa;
    logic [ADDR_W-1:0]   l_ra;
    logic [LEN_W-1:0]    l_wd;
    logic [LEN_W-1:0]    l_rd_reg;
    logic                c_we;
    logic [ADDR_W-1:0]   c_addr;
    logic [CODE_W-1:0]   c_wd;
    logic [CODE_W-1:0]   c_rd_reg;

    logic [CNT_W-1:0]        cnt_reg,   cnt_next;
    logic [CNT_W-1:0]        n_reg,     n_next;
    logic signed [PTR_W-1:0] i_reg,     i_next;
    logic signed [PTR_W-1:0] root_reg,  root_next;
    logic signed [PTR_W-1:0] leaf_reg,  leaf_next;
    logic [WEIGHT_W-1:0]     a_reg,     a_next;
    logic [WEIGHT_W-1:0]     b_reg,     b_next;
    logic                    flag_reg,  flag_next;
    logic [CNT_W-1:0]        used_reg,  used_next;
    logic [CNT_W:0]          avail_reg, avail_next;
    logic [LEN_W:0]          depth_reg, depth_next;
    logic [CNT_W-1:0]        next_reg,  next_next;
    logic [LEN_W-1:0]        bits_reg,  bits_next;
    // Code walk runs at full width so the right shift pulls in the bits above the output word.
    logic [2*CODE_W-1:0]     code_reg,  code_next;

    logic                out_valid_reg, out_valid_next;
    logic [POS_W-1:0]    pos_reg,  pos_next;
    logic [LEN_W-1:0]    len_reg,  len_next;
    logic [CODE_W-1:0]   word_reg, word_next;
    logic                few_reg,  few_next;
    logic                last_reg, last_next;

    logic signed [PTR_W-1:0] n_ptr;
    logic [CNT_W-1:0]        n_less;
    logic                    leaf_neg;
    logic                    cond1;
    logic                    cond2;
    logic [LEN_W-1:0]        sh;
    logic [2*CODE_W-1:0]     code_sum;
    logic                    out_load;
    logic                    out_free;

    assign n_ptr    = $signed({1'b0, n_reg});
    assign n_less   = n_reg - CNT_W'(1);
    assign leaf_neg = leaf_reg[PTR_W-1];
    assign cond1    = leaf_neg || (a_reg < w_rd_reg);
    assign cond2    = leaf_neg || ((root_reg > i_reg) && (a_reg < b_reg));
    assign sh       = (bits_reg >= l_rd_reg) ? (bits_reg - l_rd_reg) : '0;
    assign code_sum = code_reg + (2 * CODE_W)'(1);
    assign out_free = !out_valid_reg || out_ready;
    assign c_addr   = i_reg[ADDR_W-1:0];

    assign sts.close      = last_item || (cnt_reg == CNT_W'(MAX_SYMBOLS - 1));
    assign sts.count_zero = (cnt_reg == '0);
    assign sts.out_free   = out_free;
    assign sts.i_pos      = !i_reg[PTR_W-1] && (i_reg != '0);
    assign sts.i_lt_n     = (i_reg < n_ptr);
    assign sts.i_nonneg   = !i_reg[PTR_W-1];
    assign sts.match      = (root_reg < n_ptr) && (w_rd_reg == WEIGHT_W'(depth_reg));
    assign sts.avail_more = (avail_reg > (CNT_W + 1)'(used_reg));
    assign sts.depth_go   = (avail_reg != '0) && (depth_reg < (LEN_W + 1)'(DEPTH_LIMIT));
    assign sts.next_lt_n  = (next_reg < n_reg);
    assign sts.emit_last  = (i_reg == (n_ptr - PTR_ONE));

    always_comb
    begin
        w_we       = 1'b0;
        w_wa       = i_reg[ADDR_W-1:0];
        w_wd       = '0;
        w_ra       = i_reg[ADDR_W-1:0];
        l_we       = 1'b0;
        l_wa       = next_reg[ADDR_W-1:0];
        l_wd       = '0;
        l_ra       = i_reg[ADDR_W-1:0];
        c_we       = 1'b0;
        c_wd       = '0;
        cnt_next   = cnt_reg;
        n_next     = n_reg;
        i_next     = i_reg;
        root_next  = root_reg;
        leaf_next  = leaf_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        flag_next  = flag_reg;
        used_next  = used_reg;
        avail_next = avail_reg;
        depth_next = depth_reg;
        next_next  = next_reg;
        bits_next  = bits_reg;
        code_next  = code_reg;
        out_load   = 1'b0;
        pos_next   = '0;
        len_next   = '0;
        word_next  = '0;
        few_next   = 1'b0;
        last_next  = 1'b0;
        if (cmd.fire)
        begin
            case (cmd.op)
                OP_IDLE:
                begin
                end
                OP_LOAD:
                begin
                    w_we = 1'b1;
                    w_wa = cnt_reg[ADDR_W-1:0];
                    w_wd = WEIGHT_W'(frequency);
                    if (sts.close)
                    begin
                        cnt_next = '0;
                        n_next   = cnt_reg + CNT_W'(1);
                    end
                    else
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
                OP_FEW:
                begin
                    out_load  = 1'b1;
                    few_next  = 1'b1;
                    last_next = 1'b1;
                end
                OP_P_INIT:
                begin
                    root_next = n_ptr - PTR_ONE;
                    leaf_next = n_ptr - PTR_THREE;
                    i_next    = n_ptr - PTR_TWO;
                end
                OP_P_RD0:
                begin
                    w_ra = root_reg[ADDR_W-1:0];
                end
                OP_P_RD1:
                begin
                    a_next = w_rd_reg;
                end
                OP_P_WR0:
                begin
                    w_we = 1'b1;
                    w_wa = root_reg[ADDR_W-1:0];
                    w_wd = a_reg + w_rd_reg;
                end
                OP_P_CHK:
                begin
                end
                OP_P1A, OP_P2A:
                begin
                    w_ra = root_reg[ADDR_W-1:0];
                end
                OP_P1B, OP_P2B:
                begin
                    w_ra   = leaf_reg[ADDR_W-1:0];
                    a_next = w_rd_reg;
                end
                OP_P1C:
                begin
                    flag_next = cond1;
                    w_we      = 1'b1;
                    w_wd      = cond1 ? a_reg : w_rd_reg;
                end
                OP_P2C:
                begin
                    b_next = w_rd_reg;
                end
                OP_P2D:
                begin
                    flag_next = cond2;
                    w_we      = 1'b1;
                    w_wd      = w_rd_reg + (cond2 ? a_reg : b_reg);
                end
                OP_P1D, OP_P2E:
                begin
                    if (flag_reg)
                    begin
                        w_we      = 1'b1;
                        w_wa      = root_reg[ADDR_W-1:0];
                        w_wd      = WEIGHT_W'(i_reg[ADDR_W-1:0]);
                        root_next = root_reg - PTR_ONE;
                    end
                    else
                    begin
                        leaf_next = leaf_reg - PTR_ONE;
                    end
                    if (cmd.op == OP_P2E)
                    begin
                        i_next = i_reg - PTR_ONE;
                    end
                end
                OP_D_INIT:
                begin
                    w_we   = 1'b1;
                    w_wa   = ADDR_W'(1);
                    w_wd   = '0;
                    i_next = PTR_TWO;
                end
                OP_D_CHK, OP_D_R0:
                begin
                end
                OP_D_R1:
                begin
                    w_ra   = w_rd_reg[ADDR_W-1:0];
                    a_next = w_rd_reg;
                end
                OP_D_W:
                begin
                    w_we   = 1'b1;
                    w_wd   = (a_reg < WEIGHT_W'(i_reg[ADDR_W-1:0]))
                             ? (w_rd_reg + WEIGHT_W'(1)) : '0;
                    i_next = i_reg + PTR_ONE;
                end
                OP_L_INIT:
                begin
                    avail_next = (CNT_W + 1)'(1);
                    next_next  = '0;
                    depth_next = '0;
                    root_next  = PTR_ONE;
                end
                OP_L_CHK:
                begin
                end
                OP_L_UI:
                begin
                    used_next = '0;
                end
                OP_L_UR:
                begin
                    w_ra = root_reg[ADDR_W-1:0];
                end
                OP_L_UC:
                begin
                    if (sts.match)
                    begin
                        used_next = used_reg + CNT_W'(1);
                        root_next = root_reg + PTR_ONE;
                    end
                end
                OP_L_A:
                begin
                    if (sts.avail_more)
                    begin
                        if (sts.next_lt_n)
                        begin
                            l_we      = 1'b1;
                            l_wd      = depth_reg[LEN_W-1:0];
                            next_next = next_reg + CNT_W'(1);
                        end
                        avail_next = avail_reg - (CNT_W + 1)'(1);
                    end
                    else
                    begin
                        avail_next = {used_reg, 1'b0};
                        depth_next = depth_reg + (LEN_W + 1)'(1);
                    end
                end
                OP_L_FILL:
                begin
                    if (sts.next_lt_n)
                    begin
                        l_we      = 1'b1;
                        l_wd      = LEN_FILL;
                        next_next = next_reg + CNT_W'(1);
                    end
                end
                OP_C_INIT:
                begin
                    l_ra   = n_less[ADDR_W-1:0];
                    i_next = n_ptr - PTR_ONE;
                end
                OP_C_0:
                begin
                    bits_next = l_rd_reg;
                    code_next = '0;
                    c_we      = 1'b1;
                    c_wd      = '0;
                    i_next    = i_reg - PTR_ONE;
                end
                OP_C_CHK:
                begin
                end
                OP_C_R:
                begin
                    // Shift now, add one in the next cycle.
                    code_next = code_reg >> sh;
                end
                OP_C_W:
                begin
                    code_next = code_sum;
                    bits_next = l_rd_reg;
                    c_we      = 1'b1;
                    c_wd      = code_sum[CODE_W-1:0];
                    i_next    = i_reg - PTR_ONE;
                end
                OP_E_INIT:
                begin
                    i_next = '0;
                end
                OP_E_R:
                begin
                end
                OP_E_O:
                begin
                    out_load  = 1'b1;
                    pos_next  = POS_W'(i_reg[ADDR_W-1:0]);
                    len_next  = l_rd_reg;
                    word_next = c_rd_reg;
                    last_next = sts.emit_last;
                    i_next    = i_reg + PTR_ONE;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign out_valid_next = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk)
    begin
        if (w_we)
        begin
            w_mem[w_wa] <= w_wd;
        end
        w_rd_reg <= w_mem[w_ra];
        if (l_we)
        begin
            l_mem[l_wa] <= l_wd;
        end
        l_rd_reg <= l_mem[l_ra];
        if (c_we)
        begin
            c_mem[c_addr] <= c_wd;
        end
        c_rd_reg <= c_mem[c_addr];
        if (out_load)
        begin
            pos_reg  <= pos_next;
            len_reg  <= len_next;
            word_reg <= word_next;
            few_reg  <= few_next;
            last_reg <= last_next;
        end
        a_reg    <= a_next;
        b_reg    <= b_next;
        bits_reg <= bits_next;
        code_reg <= code_next;
        n_reg    <= n_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            i_reg         <= '0;
            root_reg      <= '0;
            leaf_reg      <= '0;
            flag_reg      <= 1'b0;
            used_reg      <= '0;
            avail_reg     <= '0;
            depth_reg     <= '0;
            next_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            i_reg         <= i_next;
            root_reg      <= root_next;
            leaf_reg      <= leaf_next;
            flag_reg      <= flag_next;
            used_reg      <= used_next;
            avail_reg     <= avail_next;
            depth_reg     <= depth_next;
            next_reg      <= next_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign position    = pos_reg;
    assign code_length = len_reg;
    assign code_word   = word_reg;
    assign too_few     = few_reg;
    assign last_result = last_reg;

    `HLCB_ASSERT_NXT(a_close_clears_count,
        cmd.fire && (cmd.op == OP_LOAD) && sts.close, (cnt_reg == '0),
        "fill count not cleared when the set closed")
    `HLCB_ASSERT_IMP(a_leaf_floor,
        (cmd.op == OP_P1A) || (cmd.op == OP_P2A), !leaf_reg[PTR_W-1] || (leaf_reg == '1),
        "leaf cursor ran below the store")
    `HLCB_ASSERT_IMP(a_next_bound,
        (cmd.op == OP_L_A) || (cmd.op == OP_L_FILL), (next_reg <= n_reg),
        "length cursor passed the set size")
    `HLCB_ASSERT_IMP(a_no_overwrite,
        out_load, !out_valid_reg || out_ready,
        "result register overwritten before it was taken")

endmodule

// ----- rtl/huffman_length_and_code_build.sv -----
// Items of a set load at one a cycle while the block is loading. The pairing, depth and
//   length phases all go through the single read port of the weight store.
// Results leave in position order, each a store read and then an output register load,
//   held while the output register is full; a one-symbol set goes from the closing item
//   to the error result state, which loads the error result once the output register is free.
// Reset: rst_n clears the sequencer, cursors and output valid; the stores are not cleared.
module huffman_length_and_code_build (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [hlcb_pkg::FREQ_W-1:0]   frequency,
    input  logic                          last_item,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [hlcb_pkg::POS_W-1:0]    position,
    output logic [hlcb_pkg::LEN_W-1:0]    code_length,
    output logic [hlcb_pkg::CODE_W-1:0]   code_word,
    output logic                          too_few,
    output logic                          last_result
);
    import hlcb_pkg::*;

    // Commands from the sequencer, status back from the datapath.
    cmd_t cmd;
    sts_t sts;

    // Sequencer: hold in loading until an item closes the set, then walk the pairing,
    // depth, length and code phases and drain the results in order (a lone symbol: error result).
    hlcb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath: weight, length and code stores, cursors, and the output register.
    // The output register lets the next set start loading while the final
    // item of the previous set still waits to be taken.
    hlcb_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .frequency   (frequency),
        .last_item   (last_item),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .position    (position),
        .code_length (code_length),
        .code_word   (code_word),
        .too_few     (too_few),
        .last_result (last_result)
    );

endmodule

// ----- dv/hlcb_checker.sv -----
`timescale 1ns / 1ps

module hlcb_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic [hlcb_pkg::FREQ_W-1:0] frequency,
    input  logic                        last_item,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [hlcb_pkg::POS_W-1:0]  position,
    input  logic [hlcb_pkg::LEN_W-1:0]  code_length,
    input  logic [hlcb_pkg::CODE_W-1:0] code_word,
    input  logic                        too_few,
    input  logic                        last_result,
    output int                          mismatch_count,
    output int                          waiting_count,
    output int                          results_checked,
    output int                          longest_length
);
    import hlcb_pkg::*;

    localparam int MAX_SHOWN = 100;

    typedef struct {
        logic [POS_W-1:0]  pos;
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
        logic              few;
        logic              last;
    } code_result_t;

    code_result_t        expected_codes[$];
    logic [WEIGHT_W-1:0] node_weight [MAX_SYMBOLS];
    int                  leaf_length [MAX_SYMBOLS];
    int                  set_fill      = 0;
    int                  fail_tally    = 0;
    int                  checked_tally = 0;
    int                  longest_tally = 0;

    task automatic report_mismatch(input string msg);
        if (fail_tally < MAX_SHOWN)
            $display("[%0t] MISMATCH %s", $time, msg);
        fail_tally++;
    endtask

    // Build lengths in place (pair, parent depths, leaf depths), then canonical codes.
    task automatic predict_code_set(input int n);
        int                  root;
        int                  leaf;
        int                  avail;
        int                  used;
        int                  next_leaf;
        int                  depth;
        int                  bits;
        int                  len;
        int                  sh;
        longint unsigned     code;
        logic [WEIGHT_W-1:0] parent;
        code_result_t        r;
        code_result_t        set_results [MAX_SYMBOLS];

        if (n < 2)
        begin
            r.pos  = '0;
            r.len  = '0;
            r.code = '0;
            r.few  = 1'b1;
            r.last = 1'b1;
            expected_codes.push_back(r);
            return;
        end

        root = n - 1;
        leaf = n - 3;
        node_weight[n-1] = node_weight[n-1] + node_weight[n-2];
        for (int i = n - 2; i > 0; i--)
        begin
            if (leaf < 0 || node_weight[root] < node_weight[leaf])
            begin
                node_weight[i]    = node_weight[root];
                node_weight[root] = WEIGHT_W'(i);
                root--;
            end
            else
            begin
                node_weight[i] = node_weight[leaf];
                leaf--;
            end
            if (leaf < 0 || (root > i && node_weight[root] < node_weight[leaf]))
            begin
                node_weight[i]    = node_weight[i] + node_weight[root];
                node_weight[root] = WEIGHT_W'(i);
                root--;
            end
            else
            begin
                node_weight[i] = node_weight[i] + node_weight[leaf];
                leaf--;
            end
        end

        node_weight[1] = '0;
        for (int i = 2; i < n; i++)
        begin
            parent = node_weight[i];
            node_weight[i] = (parent < i) ? node_weight[parent] + 1'b1 : '0;
        end

        avail     = 1;
        next_leaf = 0;
        depth     = 0;
        root      = 1;
        while (avail > 0 && depth < DEPTH_LIMIT)
        begin
            used = 0;
            while (root < n && node_weight[root] == depth)
            begin
                used++;
                root++;
            end
            while (avail > used)
            begin
                if (next_leaf < n)
                begin
                    leaf_length[next_leaf] = depth;
                    next_leaf++;
                end
                avail--;
            end
            avail = 2 * used;
            depth++;
        end
        while (next_leaf < n)
        begin
            leaf_length[next_leaf] = int'(LEN_FILL);
            next_leaf++;
        end

        // The last position takes code zero; walk back towards position 0.
        bits = leaf_length[n-1];
        code = 0;
        set_results[n-1].pos  = POS_W'(n - 1);
        set_results[n-1].len  = LEN_W'(bits);
        set_results[n-1].code = '0;
        set_results[n-1].few  = 1'b0;
        set_results[n-1].last = 1'b1;
        for (int i = n - 2; i >= 0; i--)
        begin
            len  = leaf_length[i];
            sh   = (bits >= len) ? bits - len : 0;
            code = (sh < 64) ? (code >> sh) : 64'd0;
            bits = len;
            code = code + 1;
            set_results[i].pos  = POS_W'(i);
            set_results[i].len  = LEN_W'(len);
            set_results[i].code = code[CODE_W-1:0];
            set_results[i].few  = 1'b0;
            set_results[i].last = 1'b0;
        end
        for (int i = 0; i < n; i++)
            expected_codes.push_back(set_results[i]);
    endtask

    always @(posedge clk)
    begin
        code_result_t want;
        if (rst_n)
        begin
            // Check results before taking new items, so nothing matches its own set early.
            if (out_valid && out_ready)
            begin
                if (expected_codes.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result at position %0d", position));
                end
                else
                begin
                    want = expected_codes.pop_front();
                    if (position !== want.pos)
                        report_mismatch($sformatf("position: expected %0d, got %0d",
                                                  want.pos, position));
                    if (code_length !== want.len)
                        report_mismatch($sformatf("position %0d code_length: expected %0d, got %0d",
                                                  want.pos, want.len, code_length));
                    if (code_word !== want.code)
                        report_mismatch($sformatf("position %0d code_word: expected %h, got %h",
                                                  want.pos, want.code, code_word));
                    if (too_few !== want.few)
                        report_mismatch($sformatf("position %0d too_few: expected %0d, got %0d",
                                                  want.pos, want.few, too_few));
                    if (last_result !== want.last)
                        report_mismatch($sformatf("position %0d last_result: expected %0d, got %0d",
                                                  want.pos, want.last, last_result));
                    checked_tally++;
                    if (want.len > longest_tally)
                        longest_tally = want.len;
                end
            end

            if (in_valid && in_ready)
            begin
                node_weight[set_fill] = WEIGHT_W'(frequency);
                set_fill++;
                if (last_item || set_fill == MAX_SYMBOLS)
                begin
                    predict_code_set(set_fill);
                    set_fill = 0;
                end
            end
        end
        mismatch_count  <= fail_tally;
        waiting_count   <= expected_codes.size();
        results_checked <= checked_tally;
        longest_length  <= longest_tally;
    end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import hlcb_pkg::*;

    // Random items after the directed part; the run starts no new set once this many have gone.
    localparam int DIRECTED_ITEMS = 22;
    localparam int RANDOM_ITEMS   = 400;
    // Watchdog limit; allow a wide margin over the build of a full 64-symbol set.
    localparam int STALL_LIMIT    = 20000;
    localparam int DRAIN_CYCLES   = 200;
    localparam int MAX_GAP        = 20;

    typedef enum int {
        SET_DESC_WIDE,
        SET_DESC_NARROW,
        SET_ASCENDING,
        SET_SHUFFLED
    } set_shape_t;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              in_valid    = 1'b0;
    logic              in_ready;
    logic [FREQ_W-1:0] frequency   = '0;
    logic              last_item   = 1'b0;
    logic              out_valid;
    logic              out_ready   = 1'b0;
    logic [POS_W-1:0]  position;
    logic [LEN_W-1:0]  code_length;
    logic [CODE_W-1:0] code_word;
    logic              too_few;
    logic              last_result;

    int mismatch_count;
    int waiting_count;
    int results_checked;
    int longest_length;

    // Sender gap and receiver stall chances, in percent.
    int idle_pct       = 0;
    int stall_pct      = 0;
    int items_sent     = 0;
    int sets_sent      = 0;
    int single_sets    = 0;
    int full_sets      = 0;
    int unordered_sets = 0;
    int idle_cycles    = 0;

    always #2 clk = ~clk;

    huffman_length_and_code_build DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .frequency   (frequency),
        .last_item   (last_item),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .position    (position),
        .code_length (code_length),
        .code_word   (code_word),
        .too_few     (too_few),
        .last_result (last_result)
    );

    hlcb_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .frequency       (frequency),
        .last_item       (last_item),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .position        (position),
        .code_length     (code_length),
        .code_word       (code_word),
        .too_few         (too_few),
        .last_result     (last_result),
        .mismatch_count  (mismatch_count),
        .waiting_count   (waiting_count),
        .results_checked (results_checked),
        .longest_length  (longest_length)
    );

    // Receiver: drop ready at random, at the rate of the current phase.
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    // Watchdog: count cycles in which neither channel moves an item.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Timed out after %0d cycles with no item moving", idle_cycles);
            $display("Mismatches found");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one item, holding valid and payload until accepted. Lower valid only for a gap.
    task automatic send_item(input int value, input bit closing);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        frequency <= FREQ_W'(value);
        last_item <= closing;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
    endtask

    // Send one set of the given size and shape. A full store closes on its own,
    // so the final flag of a 64-symbol set is left to chance.
    task automatic send_set(input int count, input set_shape_t shape);
        int value;
        bit closing;

        sets_sent++;
        if (count == 1)
            single_sets++;
        if (count == MAX_SYMBOLS)
            full_sets++;
        if (shape == SET_ASCENDING || shape == SET_SHUFFLED)
            unordered_sets++;

        case (shape)
            SET_DESC_WIDE:   value = ($urandom_range(3) == 0) ? 65535 : $urandom_range(65535, 1);
            SET_DESC_NARROW: value = $urandom_range(65535, 1);
            SET_ASCENDING:   value = $urandom_range(8, 1);
            default:         value = $urandom_range(65535, 1);
        endcase

        for (int k = 0; k < count; k++)
        begin
            if (k < count - 1)
                closing = 1'b0;
            else if (count == MAX_SYMBOLS)
                closing = $urandom_range(1);
            else
                closing = 1'b1;
            send_item(value, closing);

            // Advance the value: shrink for decreasing sets, grow by up to double for ascending ones.
            case (shape)
                SET_DESC_WIDE:   value = value - $urandom_range(value / 4, 0);
                SET_DESC_NARROW: value = value - $urandom_range(2, 0);
                SET_ASCENDING:   value = value + $urandom_range(value, 0);
                default:         value = $urandom_range(65535, 1);
            endcase
            if (value < 1)
                value = 1;
            if (value > 65535)
                value = 65535;
        end
    endtask

    initial
    begin
        int         size_pick;
        int         shape_pick;
        int         set_size;
        int         progress;
        set_shape_t shape;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Lone symbol: only the error result comes back.
        send_item(1234, 1'b1);
        // Two symbols at the field extremes.
        send_item(65535, 1'b0);
        send_item(1, 1'b1);
        // Equal counts: every tie taken the same way, balanced tree.
        for (int k = 0; k < 4; k++)
            send_item(5, k == 3);
        // Three at the maximum: sums carry past sixteen bits.
        for (int k = 0; k < 3; k++)
            send_item(65535, k == 2);
        // Out of order, doubling: not minimal, deep codes.
        for (int k = 0; k < 6; k++)
            send_item(1 << k, k == 5);
        // Ordinary decreasing set with a tie in the middle.
        send_item(9000, 1'b0);
        send_item(700, 1'b0);
        send_item(700, 1'b0);
        send_item(60, 1'b0);
        send_item(3, 1'b0);
        send_item(1, 1'b1);
        sets_sent      += 6;
        single_sets    += 1;
        unordered_sets += 1;

        // Open with a store-full set, then random sets through four idling phases.
        send_set(MAX_SYMBOLS, SET_DESC_WIDE);
        while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS)
        begin
            progress = (items_sent - DIRECTED_ITEMS) * 4 / RANDOM_ITEMS;
            case (progress)
                0:       begin idle_pct = 0;  stall_pct <= 0;  end
                1:       begin idle_pct = 54; stall_pct <= 0;  end
                2:       begin idle_pct = 0;  stall_pct <= 54; end
                default: begin idle_pct = 10; stall_pct <= 10; end
            endcase

            // Mostly small sets; a few large and full ones.
            size_pick = $urandom_range(99);
            if (size_pick < 6)
                set_size = 1;
            else if (size_pick < 70)
                set_size = $urandom_range(8, 2);
            else if (size_pick < 88)
                set_size = $urandom_range(24, 9);
            else if (size_pick < 94)
                set_size = $urandom_range(MAX_SYMBOLS - 1, 25);
            else
                set_size = MAX_SYMBOLS;

            // Mostly well-formed decreasing sets; the rest out of order.
            shape_pick = $urandom_range(99);
            if (shape_pick < 50)
                shape = SET_DESC_WIDE;
            else if (shape_pick < 75)
                shape = SET_DESC_NARROW;
            else if (shape_pick < 85)
                shape = SET_ASCENDING;
            else
                shape = SET_SHUFFLED;

            send_set(set_size, shape);
        end
        in_valid <= 1'b0;

        // Hold until every predicted result has come, then let the block settle.
        do
            @(posedge clk);
        while (waiting_count != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d items in %0d sets: %0d lone-symbol, %0d full-store, %0d out of order",
                 items_sent, sets_sent, single_sets, full_sets, unordered_sets);
        $display("%0d results compared, longest code length %0d, %0d mismatches",
                 results_checked, longest_length, mismatch_count);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
